>>> src/msse_pkg.sv
// shared types and constants of the mips subset step executor
`default_nettype none
package msse_pkg;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_END     = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_ADDR    = 3'd3,
		ST_HALTED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_FETCH,
		S_EXEC,
		S_LOADWB,
		S_FINISH
	} state_t;

	// opcodes
	localparam logic [5:0] OP_SPECIAL = 6'b000000;
	localparam logic [5:0] OP_SW      = 6'b101011;
	localparam logic [5:0] OP_LW      = 6'b100011;
	localparam logic [5:0] OP_BNE     = 6'b000101;
	localparam logic [5:0] OP_BEQ     = 6'b000100;
	localparam logic [5:0] OP_BLEZ    = 6'b000110;
	localparam logic [5:0] OP_BGTZ    = 6'b000111;
	localparam logic [5:0] OP_J       = 6'b000010;
	localparam logic [5:0] OP_JAL     = 6'b000011;

	// function codes of the special opcode
	localparam logic [5:0] FN_ADD = 6'b100000;
	localparam logic [5:0] FN_SUB = 6'b100010;
	localparam logic [5:0] FN_SLL = 6'b000000;
	localparam logic [5:0] FN_SRL = 6'b000010;
	localparam logic [5:0] FN_JR  = 6'b001000;

	// configuration register indexes
	localparam logic [2:0] CFG_ALU    = 3'd0;
	localparam logic [2:0] CFG_SHIFT  = 3'd1;
	localparam logic [2:0] CFG_LOAD   = 3'd2;
	localparam logic [2:0] CFG_STORE  = 3'd3;
	localparam logic [2:0] CFG_BRANCH = 3'd4;
	localparam logic [2:0] CFG_JUMP   = 3'd5;

	localparam logic [7:0] COST_RESET = 8'd1;

	// commands from controller to datapath
	typedef struct packed {
		logic    clear_step;
		logic    capture;
		logic    load_item;
		logic    fetch;
		logic    decode;
		logic    load_rd;
		logic    commit;
		logic    halt;
		logic    set_st;
		status_t st;
		logic    emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_done;
		logic kind;
		logic halted;
		logic pc_bad;
		logic load_ok;
		logic word_valid;
		logic bad_op;
		logic mem_op;
		logic addr_bad;
		logic is_lw;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

>>> src/msse_if.sv
// item and result channel interfaces
`default_nettype none
interface msse_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [11:0] load_address;
	logic [31:0] load_word;
	modport source (output valid, output kind, output load_address, output load_word,
		input ready);
	modport sink (input valid, input kind, input load_address, input load_word,
		output ready);
endinterface

interface msse_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] next_pc;
	logic [31:0] executed_count;
	logic [47:0] cycle_total;
	modport source (output valid, output status, output next_pc, output executed_count,
		output cycle_total, input ready);
	modport sink (input valid, input status, input next_pc, input executed_count,
		input cycle_total, output ready);
endinterface
`default_nettype wire

>>> src/msse_ctrl.sv
// controller state machine of the step executor
`default_nettype none
module msse_ctrl
	import msse_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_done) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nx = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (!sts.kind || sts.halted || sts.pc_bad) state_nx = S_FINISH;
				else state_nx = S_FETCH;
			end
			S_FETCH: begin
				if (!sts.word_valid) state_nx = S_FINISH;
				else state_nx = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.bad_op && !(sts.mem_op && sts.addr_bad) && sts.is_lw) state_nx = S_LOADWB;
				else state_nx = S_FINISH;
			end
			S_LOADWB: state_nx = S_FINISH;
			S_FINISH: begin
				if (!sts.out_busy) state_nx = S_IDLE;
			end
			default: state_nx = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.st   = ST_OK;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clear_step = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_DISPATCH: begin
				if (!sts.kind) begin
					cmd.load_item = 1'b1;
					cmd.set_st    = 1'b1;
					cmd.st        = sts.load_ok ? ST_OK : ST_ADDR;
				end else if (sts.halted) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_HALTED;
				end else if (sts.pc_bad) begin
					cmd.halt   = 1'b1;
					cmd.set_st = 1'b1;
					cmd.st     = ST_END;
				end else begin
					cmd.fetch = 1'b1;
				end
			end
			S_FETCH: begin
				if (!sts.word_valid) begin
					cmd.halt   = 1'b1;
					cmd.set_st = 1'b1;
					cmd.st     = ST_END;
				end else begin
					cmd.decode = 1'b1;
				end
			end
			S_EXEC: begin
				if (sts.bad_op) begin
					cmd.halt   = 1'b1;
					cmd.set_st = 1'b1;
					cmd.st     = ST_UNKNOWN;
				end else if (sts.mem_op && sts.addr_bad) begin
					cmd.halt   = 1'b1;
					cmd.set_st = 1'b1;
					cmd.st     = ST_ADDR;
				end else if (sts.is_lw) begin
					cmd.load_rd = 1'b1;
				end else begin
					cmd.commit = 1'b1;
					cmd.set_st = 1'b1;
				end
			end
			S_LOADWB: begin
				cmd.commit = 1'b1;
				cmd.set_st = 1'b1;
			end
			S_FINISH: cmd.emit = !sts.out_busy;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> src/msse_dp.sv
// datapath: word memory, register file, program state and result register
`default_nettype none
module msse_dp
	import msse_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        in_kind,
	input  wire logic [11:0] in_load_address,
	input  wire logic [31:0] in_load_word,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_status,
	output logic [31:0]      out_next_pc,
	output logic [31:0]      out_executed_count,
	output logic [47:0]      out_cycle_total
);

	localparam int AW = $clog2(MEM_WORDS);

	function automatic logic [31:0] rf_reset(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'd2;
			5'd1:    v = 32'd1;
			5'd29:   v = 32'd4095;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// word memory and its valid store
	logic [31:0] mem [MEM_WORDS];
	logic        vld_mem [MEM_WORDS];
	logic [31:0] mem_rd_q;
	logic        vld_rd_q;
	logic [AW-1:0] clr_q;

	// register file with per-entry written marks
	logic [31:0] rf_mem [32];
	logic [31:0] rf_ok_q;
	logic [31:0] rs_raw_q, rt_raw_q;
	logic        rs_ok_q, rt_ok_q;
	logic [4:0]  rs_idx_q, rt_idx_q;

	logic        kind_q;
	logic [11:0] ld_addr_q;
	logic [31:0] ld_word_q;
	logic [31:0] instr_q;
	logic [31:0] pc_q, cnt_q;
	logic [47:0] cyc_q;
	logic        halted_q;
	status_t     st_q;
	logic [7:0]  c_alu_q, c_shift_q, c_load_q, c_store_q, c_branch_q, c_jump_q;

	logic        out_valid_q;
	status_t     out_st_q;
	logic [31:0] out_pc_q, out_cnt_q;
	logic [47:0] out_cyc_q;

	// decode fields
	logic [5:0]  op, fn;
	logic [4:0]  rd, sh;
	logic [15:0] imm;
	logic [25:0] tgt;
	logic [31:0] rs_val, rt_val;
	logic        is_alu, is_shift, is_ld, is_st, is_br, is_jmp, bad;
	logic        taken;
	logic [31:0] alu_res, next_pc;
	logic [7:0]  cost;
	logic [33:0] dsum;
	logic        addr_bad;
	logic [AW-1:0] d_idx, f_idx, ld_idx;
	logic [31:0] ld_ext, pc_m1;
	logic        load_ok, pc_bad;

	logic          mem_we, mem_re, vld_we, vld_wd;
	logic [AW-1:0] mem_wa, mem_ra, vld_wa;
	logic [31:0]   mem_wd;
	logic          rf_we;
	logic [4:0]    rf_wa;
	logic [31:0]   rf_wd;

	assign op  = instr_q[31:26];
	assign fn  = instr_q[5:0];
	assign rd  = instr_q[15:11];
	assign sh  = instr_q[10:6];
	assign imm = instr_q[15:0];
	assign tgt = instr_q[25:0];

	assign rs_val = rs_ok_q ? rs_raw_q : rf_reset(rs_idx_q);
	assign rt_val = rt_ok_q ? rt_raw_q : rf_reset(rt_idx_q);

	always_comb begin
		is_alu   = 1'b0;
		is_shift = 1'b0;
		is_ld    = 1'b0;
		is_st    = 1'b0;
		is_br    = 1'b0;
		is_jmp   = 1'b0;
		bad      = 1'b0;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_ADD, FN_SUB: is_alu = 1'b1;
					FN_SLL, FN_SRL: is_shift = 1'b1;
					FN_JR:          is_jmp = 1'b1;
					default:        bad = 1'b1;
				endcase
			end
			OP_SW:                             is_st = 1'b1;
			OP_LW:                             is_ld = 1'b1;
			OP_BNE, OP_BEQ, OP_BLEZ, OP_BGTZ:  is_br = 1'b1;
			OP_J, OP_JAL:                      is_jmp = 1'b1;
			default:                           bad = 1'b1;
		endcase
	end

	always_comb begin
		case (fn)
			FN_ADD:  alu_res = rs_val + rt_val;
			FN_SUB:  alu_res = rs_val - rt_val;
			FN_SLL:  alu_res = rt_val << sh;
			FN_SRL:  alu_res = rt_val >> sh;
			default: alu_res = 32'd0;
		endcase
	end

	always_comb begin
		case (op)
			OP_BNE:  taken = rs_val != rt_val;
			OP_BEQ:  taken = rs_val == rt_val;
			OP_BLEZ: taken = rs_val[31] || (rs_val == 32'd0);
			OP_BGTZ: taken = !rs_val[31] && (rs_val != 32'd0);
			default: taken = 1'b0;
		endcase
	end

	always_comb begin
		next_pc = pc_q + 32'd1;
		if (is_br && taken) next_pc = pc_q + {16'd0, imm};
		else if (op == OP_J || op == OP_JAL) next_pc = {6'd0, tgt} + 32'd1;
		else if (is_jmp) next_pc = rs_val + 32'd1;
	end

	always_comb begin
		cost = c_jump_q;
		if (is_alu) cost = c_alu_q;
		else if (is_shift) cost = c_shift_q;
		else if (is_ld) cost = c_load_q;
		else if (is_st) cost = c_store_q;
		else if (is_br) cost = c_branch_q;
	end

	// data address: unsigned offset plus signed base
	assign dsum     = {18'd0, imm} + {{2{rs_val[31]}}, rs_val};
	assign addr_bad = dsum[33] || (dsum[32:0] >= 33'(MEM_WORDS));
	assign d_idx    = dsum[AW-1:0];

	assign pc_bad  = (pc_q == 32'd0) || (pc_q > 32'(MEM_WORDS));
	assign pc_m1   = pc_q - 32'd1;
	assign f_idx   = pc_m1[AW-1:0];
	assign ld_ext  = {20'd0, ld_addr_q};
	assign load_ok = ld_ext < 32'(MEM_WORDS);
	assign ld_idx  = ld_ext[AW-1:0];

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ld_idx;
		mem_wd = ld_word_q;
		vld_we = 1'b0;
		vld_wa = ld_idx;
		vld_wd = 1'b1;
		if (cmd.clear_step) begin
			vld_we = 1'b1;
			vld_wa = clr_q;
			vld_wd = 1'b0;
		end else if (cmd.load_item && load_ok) begin
			mem_we = 1'b1;
			vld_we = 1'b1;
		end else if (cmd.commit && is_st) begin
			mem_we = 1'b1;
			mem_wa = d_idx;
			mem_wd = rt_val;
			vld_we = 1'b1;
			vld_wa = d_idx;
		end
	end

	assign mem_re = cmd.fetch || cmd.load_rd;
	assign mem_ra = cmd.fetch ? f_idx : d_idx;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[vld_wa] <= vld_wd;
		if (cmd.fetch) vld_rd_q <= vld_mem[f_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// register file write
	always_comb begin
		rf_we = 1'b0;
		rf_wa = rd;
		rf_wd = alu_res;
		if (cmd.commit) begin
			if (is_alu || is_shift) begin
				rf_we = 1'b1;
			end else if (op == OP_JAL) begin
				rf_we = 1'b1;
				rf_wa = 5'd31;
				rf_wd = pc_q;
			end else if (is_ld) begin
				rf_we = 1'b1;
				rf_wa = instr_q[20:16];
				rf_wd = mem_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_wa] <= rf_wd;
		if (cmd.decode) begin
			rs_raw_q <= rf_mem[mem_rd_q[25:21]];
			rt_raw_q <= rf_mem[mem_rd_q[20:16]];
			rs_ok_q  <= rf_ok_q[mem_rd_q[25:21]];
			rt_ok_q  <= rf_ok_q[mem_rd_q[20:16]];
			rs_idx_q <= mem_rd_q[25:21];
			rt_idx_q <= mem_rd_q[20:16];
			instr_q  <= mem_rd_q;
		end
		if (cmd.capture) begin
			kind_q    <= in_kind;
			ld_addr_q <= in_load_address;
			ld_word_q <= in_load_word;
		end
		if (cmd.set_st) st_q <= cmd.st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_ok_q  <= '0;
			pc_q     <= 32'd1;
			cnt_q    <= 32'd0;
			cyc_q    <= 48'd0;
			halted_q <= 1'b0;
		end else begin
			if (rf_we) rf_ok_q[rf_wa] <= 1'b1;
			if (cmd.halt) halted_q <= 1'b1;
			if (cmd.commit) begin
				pc_q  <= next_pc;
				cnt_q <= cnt_q + 32'd1;
				cyc_q <= cyc_q + {40'd0, cost};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_alu_q    <= COST_RESET;
			c_shift_q  <= COST_RESET;
			c_load_q   <= COST_RESET;
			c_store_q  <= COST_RESET;
			c_branch_q <= COST_RESET;
			c_jump_q   <= COST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALU:    c_alu_q    <= cfg_data;
				CFG_SHIFT:  c_shift_q  <= cfg_data;
				CFG_LOAD:   c_load_q   <= cfg_data;
				CFG_STORE:  c_store_q  <= cfg_data;
				CFG_BRANCH: c_branch_q <= cfg_data;
				CFG_JUMP:   c_jump_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_st_q  <= st_q;
			out_pc_q  <= pc_q;
			out_cnt_q <= cnt_q;
			out_cyc_q <= cyc_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_status         = out_st_q;
	assign out_next_pc        = out_pc_q;
	assign out_executed_count = out_cnt_q;
	assign out_cycle_total    = out_cyc_q;

	assign sts.clear_done = clr_q == AW'(MEM_WORDS - 1);
	assign sts.kind       = kind_q;
	assign sts.halted     = halted_q;
	assign sts.pc_bad     = pc_bad;
	assign sts.load_ok    = load_ok;
	assign sts.word_valid = vld_rd_q;
	assign sts.bad_op     = bad;
	assign sts.mem_op     = is_ld || is_st;
	assign sts.addr_bad   = addr_bad;
	assign sts.is_lw      = is_ld;
	assign sts.out_busy   = out_valid_q && !out_ready;

endmodule
`default_nettype wire

>>> src/mips_subset_step_executor_core.sv
// top level of the mips subset step executor
// Runs a small mips subset out of one word memory that holds program and data. A load item
// (kind 0) writes a word and marks it valid; an execute item (kind 1) runs one instruction at
// the one-based program counter and reports status, next pc, instruction count and summed cycle
// cost. After reset the block sweeps the valid marks to zero and takes no item then; cost
// register writes are taken at any time. The fetch and the data read share the read port of
// the word memory, used in turn, and the register file has a registered read. One item is
// in flight at a time; a finished result sits in the output register while the next item is
// taken in.
`default_nettype none
module mips_subset_step_executor_core
	import msse_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msse_item_if.sink  item,
	msse_res_if.source result,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	// command and status between controller and datapath
	cmd_t cmd;
	sts_t sts;

	msse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msse_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_kind            (item.kind),
		.in_load_address    (item.load_address),
		.in_load_word       (item.load_word),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.out_status         (result.status),
		.out_next_pc        (result.next_pc),
		.out_executed_count (result.executed_count),
		.out_cycle_total    (result.cycle_total)
	);

endmodule
`default_nettype wire

>>> src/msse_checker.sv
// port-level checks of the step executor and their binding
`default_nettype none
module msse_checker
	import msse_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  out_status,
	input wire logic [31:0] out_next_pc
);

	// a result held back keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_next_pc))
		else $error("result changed while stalled");

	// status code within its defined range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == ST_OK || out_status == ST_END || out_status == ST_UNKNOWN
			|| out_status == ST_ADDR || out_status == ST_HALTED))
		else $error("status code out of range");

	// one item at a time: busy right after a transfer in
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous one in flight");

endmodule

bind mips_subset_step_executor_core msse_checker u_msse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_status  (result.status),
	.out_next_pc (result.next_pc)
);
`default_nettype wire

>>> tb/mips_subset_step_executor_core_tb.sv
// testbench for the mips subset step executor: random well-formed programs against a predictor
`default_nettype none

typedef struct {
	logic [2:0]  status;
	logic [31:0] next_pc;
	logic [31:0] executed_count;
	logic [47:0] cycle_total;
} msse_result_t;

class msse_scoreboard;
	localparam int MW = 4096;
	logic [31:0] regs [32];
	logic [31:0] mem [MW];
	bit          vld [MW];
	logic [31:0] pc;
	logic [31:0] icount;
	logic [47:0] cyc;
	bit          halted;
	logic [7:0]  cost [6];
	msse_result_t expected_results [$];
	int          errs;

	function new();
		foreach (regs[i]) regs[i] = '0;
		regs[0] = 32'd2;
		regs[1] = 32'd1;
		regs[29] = 32'd4095;
		foreach (vld[i]) vld[i] = 1'b0;
		pc = 32'd1;
		icount = '0;
		cyc = '0;
		halted = 1'b0;
		foreach (cost[i]) cost[i] = msse_pkg::COST_RESET;
		errs = 0;
	endfunction

	// decode one word against the present state without changing it
	function void plan(input logic [31:0] w, output bit ok, output int cls,
		output logic [31:0] nxt, output longint ea, output int memk,
		output bit wr, output logic [4:0] wr_idx, output logic [31:0] wr_val);
		logic [4:0] rs, rt, rd, sh;
		logic [15:0] imm;
		rs = w[25:21];
		rt = w[20:16];
		rd = w[15:11];
		sh = w[10:6];
		imm = w[15:0];
		ok = 1'b1;
		cls = msse_pkg::CFG_ALU;
		nxt = pc + 32'd1;
		memk = 0;
		wr = 1'b0;
		wr_idx = rd;
		wr_val = '0;
		ea = longint'(imm) + longint'($signed(regs[rs]));
		case (w[31:26])
			msse_pkg::OP_SPECIAL: begin
				case (w[5:0])
					msse_pkg::FN_ADD: begin
						wr = 1'b1; wr_val = regs[rs] + regs[rt];
					end
					msse_pkg::FN_SUB: begin
						wr = 1'b1; wr_val = regs[rs] - regs[rt];
					end
					msse_pkg::FN_SLL: begin
						wr = 1'b1; wr_val = regs[rt] << sh; cls = msse_pkg::CFG_SHIFT;
					end
					msse_pkg::FN_SRL: begin
						wr = 1'b1; wr_val = regs[rt] >> sh; cls = msse_pkg::CFG_SHIFT;
					end
					msse_pkg::FN_JR: begin
						nxt = regs[rs] + 32'd1; cls = msse_pkg::CFG_JUMP;
					end
					default: ok = 1'b0;
				endcase
			end
			msse_pkg::OP_SW: begin
				memk = 1; cls = msse_pkg::CFG_STORE;
			end
			msse_pkg::OP_LW: begin
				memk = 2; cls = msse_pkg::CFG_LOAD;
			end
			msse_pkg::OP_BNE: begin
				if (regs[rs] != regs[rt]) nxt = pc + {16'd0, imm};
				cls = msse_pkg::CFG_BRANCH;
			end
			msse_pkg::OP_BEQ: begin
				if (regs[rs] == regs[rt]) nxt = pc + {16'd0, imm};
				cls = msse_pkg::CFG_BRANCH;
			end
			msse_pkg::OP_BLEZ: begin
				if ($signed(regs[rs]) <= 0) nxt = pc + {16'd0, imm};
				cls = msse_pkg::CFG_BRANCH;
			end
			msse_pkg::OP_BGTZ: begin
				if ($signed(regs[rs]) > 0) nxt = pc + {16'd0, imm};
				cls = msse_pkg::CFG_BRANCH;
			end
			msse_pkg::OP_J: begin
				nxt = {6'd0, w[25:0]} + 32'd1; cls = msse_pkg::CFG_JUMP;
			end
			msse_pkg::OP_JAL: begin
				wr = 1'b1; wr_idx = 5'd31; wr_val = pc;
				nxt = {6'd0, w[25:0]} + 32'd1; cls = msse_pkg::CFG_JUMP;
			end
			default: ok = 1'b0;
		endcase
	endfunction

	// true when the word would run cleanly and leave the pc inside memory
	function bit is_safe(logic [31:0] w);
		bit ok, wr;
		int cls, memk;
		logic [31:0] nxt, wv;
		longint ea;
		logic [4:0] wi;
		plan(w, ok, cls, nxt, ea, memk, wr, wi, wv);
		if (!ok) return 1'b0;
		if (memk != 0 && (ea < 0 || ea >= MW)) return 1'b0;
		if (memk == 2 && !vld[ea]) return 1'b0;
		return nxt >= 1 && nxt <= MW;
	endfunction

	function msse_pkg::status_t run_one();
		bit ok, wr;
		int cls, memk;
		logic [31:0] nxt, wv, w;
		longint ea;
		logic [4:0] wi;
		if (pc == 0 || pc > MW || !vld[pc - 1]) begin
			halted = 1'b1;
			return msse_pkg::ST_END;
		end
		w = mem[pc - 1];
		plan(w, ok, cls, nxt, ea, memk, wr, wi, wv);
		if (!ok) begin
			halted = 1'b1;
			return msse_pkg::ST_UNKNOWN;
		end
		if (memk != 0 && (ea < 0 || ea >= MW)) begin
			halted = 1'b1;
			return msse_pkg::ST_ADDR;
		end
		if (memk == 1) begin
			mem[ea] = regs[w[20:16]];
			vld[ea] = 1'b1;
		end
		if (memk == 2) regs[w[20:16]] = mem[ea];
		if (wr) regs[wi] = wv;
		pc = nxt;
		icount = icount + 32'd1;
		cyc = cyc + {40'd0, cost[cls]};
		return msse_pkg::ST_OK;
	endfunction

	// accepted input transfer
	function void note(bit kind, logic [11:0] addr, logic [31:0] word);
		msse_result_t r;
		msse_pkg::status_t st;
		if (kind == 1'b0) begin
			mem[addr] = word;
			vld[addr] = 1'b1;
			st = msse_pkg::ST_OK;
		end else if (halted) begin
			st = msse_pkg::ST_HALTED;
		end else begin
			st = run_one();
		end
		r.status = st;
		r.next_pc = pc;
		r.executed_count = icount;
		r.cycle_total = cyc;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// accepted result transfer
	function void check(msse_result_t got);
		msse_result_t e;
		if (expected_results.size() == 0) begin
			errs++;
			if (errs <= 10) $display("unexpected result, status %0d", got.status);
			return;
		end
		e = expected_results.pop_front();
		if (got.status !== e.status || got.next_pc !== e.next_pc ||
				got.executed_count !== e.executed_count || got.cycle_total !== e.cycle_total) begin
			errs++;
			if (errs <= 10)
				$display("mismatch: exp st %0d pc %0d cnt %0d cyc %0d, got st %0d pc %0d cnt %0d cyc %0d",
					e.status, e.next_pc, e.executed_count, e.cycle_total,
					got.status, got.next_pc, got.executed_count, got.cycle_total);
		end
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module mips_subset_step_executor_core_tb;
	import msse_pkg::*;

	localparam int MW = 4096;
	localparam int IDLE_LIMIT = 20000;

	// instruction kinds the program generator can emit
	typedef enum int {
		I_ADD, I_SUB, I_SLL, I_SRL, I_SW, I_LW, I_BNE, I_BEQ, I_BLEZ, I_BGTZ,
		I_J, I_JAL, I_JR, I_COUNT
	} ikind_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	msse_item_if item_ch ();
	msse_res_if  res_ch ();

	msse_scoreboard sb;
	bit  in_steady;           // sender runs without gaps
	bit  out_steady = 1'b0;   // receiver runs without stalls
	int  quiet_cycles = 0;
	int  checked = 0;

	mips_subset_step_executor_core #(.MEM_WORDS(MW)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one input transfer; valid is left high so back-to-back items follow without a gap
	task automatic send(bit kind, logic [11:0] addr, logic [31:0] word);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= kind;
		item_ch.load_address <= addr;
		item_ch.load_word <= word;
		do @(posedge clk); while (!item_ch.ready);
		sb.note(kind, addr, word);
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_costs(logic [7:0] alu, logic [7:0] shf, logic [7:0] ld,
		logic [7:0] st, logic [7:0] br, logic [7:0] jmp);
		logic [7:0] v [6];
		v = '{alu, shf, ld, st, br, jmp};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= v[i];
			sb.cost[i] = v[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] make_word(ikind_t k);
		logic [4:0] rs, rt, rd, sh;
		logic [15:0] imm;
		longint tgt, off;
		rs = 5'($urandom);
		rt = 5'($urandom);
		rd = 5'($urandom);
		sh = 5'($urandom);
		imm = 16'($urandom);
		case (k)
			I_ADD: return {OP_SPECIAL, rs, rt, rd, sh, FN_ADD};
			I_SUB: return {OP_SPECIAL, rs, rt, rd, sh, FN_SUB};
			I_SLL: return {OP_SPECIAL, rs, rt, rd, sh, FN_SLL};
			I_SRL: return {OP_SPECIAL, rs, rt, rd, sh, FN_SRL};
			I_SW, I_LW: begin
				tgt = $urandom_range(0, MW - 1);
				// loads aim at words already written
				if (k == I_LW)
					for (int i = 0; i < 16 && !sb.vld[tgt]; i++) tgt = $urandom_range(0, MW - 1);
				off = tgt - longint'($signed(sb.regs[rs]));
				if (off >= 0 && off <= 65535) imm = 16'(off);
				return {(k == I_SW) ? OP_SW : OP_LW, rs, rt, imm};
			end
			I_BNE, I_BEQ, I_BLEZ, I_BGTZ: begin
				if ($urandom_range(0, 3) != 0) imm = 16'($urandom_range(0, MW - sb.pc));
				case (k)
					I_BNE:   return {OP_BNE, rs, rt, imm};
					I_BEQ:   return {OP_BEQ, rs, rt, imm};
					I_BLEZ:  return {OP_BLEZ, rs, rt, imm};
					default: return {OP_BGTZ, rs, rt, imm};
				endcase
			end
			I_J:   return {OP_J, 26'($urandom_range(0, MW - 1))};
			I_JAL: return {OP_JAL, 26'($urandom_range(0, MW - 1))};
			default: return {OP_SPECIAL, (sb.regs[31] < MW) ? 5'd31 : rs, rt, rd, sh, FN_JR};
		endcase
	endfunction

	function automatic logic [31:0] safe_word(ikind_t k);
		logic [31:0] w;
		for (int i = 0; i < 40; i++) begin
			w = make_word(k);
			if (sb.is_safe(w)) return w;
		end
		return make_word(I_J);
	endfunction

	// execute at the pc, first placing a clean instruction there when the present one would stop
	task automatic step_program(ikind_t k, bit force_new);
		logic [31:0] idx;
		idx = sb.pc - 32'd1;
		if (force_new || !sb.vld[idx] || !sb.is_safe(sb.mem[idx]))
			send(1'b0, idx[11:0], safe_word(k));
		send(1'b1, 12'($urandom), $urandom);
	endtask

	// receiver: random stalls, ready only lowered when a stall is drawn
	initial begin
		msse_result_t got;
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (checked % 200 == 0) out_steady = ($urandom_range(0, 3) == 0);
			stall = out_steady ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got.status = res_ch.status;
			got.next_pc = res_ch.next_pc;
			got.executed_count = res_ch.executed_count;
			got.cycle_total = res_ch.cycle_total;
			sb.check(got);
			checked++;
		end
	end

	initial begin
		int n;
		int halt_mode;
		logic [31:0] t;
		sb = new();
		in_steady = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ALU;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.kind <= 1'b0;
		item_ch.load_address <= '0;
		item_ch.load_word <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every instruction once at reset costs, extreme load fields
		send(1'b0, 12'hFFF, 32'hFFFF_FFFF);
		send(1'b0, 12'h000, 32'h0000_0000);
		for (int k = 0; k < I_COUNT; k++) step_program(ikind_t'(k), 1'b1);
		drain();

		// cost phases: zero, full scale, then random
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_costs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
				1: set_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
				default: set_costs(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			in_steady = (ph == 2);
			n = 0;
			while (n < 300) begin
				if ($urandom_range(0, 9) < 2) begin
					// noise: random word anywhere, may land on live code
					send(1'b0, 12'($urandom), $urandom);
					n++;
				end else begin
					step_program(ikind_t'($urandom_range(0, I_COUNT - 1)),
						$urandom_range(0, 3) == 0);
					n += 2;
				end
			end
			drain();
		end
		in_steady = 1'b0;

		// halting is permanent, so one halt cause per run
		halt_mode = $urandom_range(0, 3);
		t = sb.pc - 32'd1;
		case (halt_mode)
			0: send(1'b0, t[11:0], {6'b111111, 26'($urandom)});
			1: send(1'b0, t[11:0], {OP_SPECIAL, 20'($urandom), 6'b000001});
			2: send(1'b0, t[11:0], {OP_SW, 5'($urandom), 5'($urandom), 16'hFFFF});
			default: begin
				// jump to a word never written, or past the end of memory
				t = MW;
				for (int i = MW - 1; i >= 0 && t == MW; i--) if (!sb.vld[i]) t = i;
				send(1'b0, 12'(sb.pc - 1), {OP_J, 26'(t)});
				send(1'b1, '0, '0);
			end
		endcase
		for (int i = 0; i < 3; i++) send(1'b1, 12'($urandom), $urandom);
		send(1'b0, 12'($urandom), $urandom);
		send(1'b1, '0, '0);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errs == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
